### sv/eca_pkg.sv
`default_nettype none
package eca_pkg;

	// counter reading width (primary and secondary)
	localparam int CNT_W = 48;
	// power and time operand width
	localparam int PWR_W = 32;
	localparam int TIME_W = 32;
	localparam int PROD_W = PWR_W + TIME_W;
	localparam int FRAC_W = 16;
	// energy accumulator width
	localparam int TOTAL_W = 64;
	// widest delta: a wrap sum needs one bit over the counter,
	// a power estimate needs PROD_W - FRAC_W bits
	localparam int DELTA_W = (CNT_W + 1 > PROD_W - FRAC_W) ? CNT_W + 1 : PROD_W - FRAC_W;

	// configuration register indexes
	localparam logic CFG_PRIMARY_MAX_RANGE = 1'b0;
	localparam logic CFG_FALLBACK_POWER    = 1'b1;

	typedef enum logic [1:0] {
		SRC_PRIMARY  = 2'd0,
		SRC_SECONDARY = 2'd1,
		SRC_POWER    = 2'd2,
		SRC_FALLBACK = 2'd3
	} src_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		src_t               src;
	} entry_t;

endpackage
`default_nettype wire

### sv/eca_front.sv
`default_nettype none
module eca_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration writes
	input  wire logic                        cfg_valid,
	input  wire logic                        cfg_index,
	input  wire logic [eca_pkg::CNT_W-1:0]   cfg_data,
	// sample input
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        primary_present,
	input  wire logic [eca_pkg::CNT_W-1:0]   primary_reading,
	input  wire logic                        secondary_present,
	input  wire logic [eca_pkg::CNT_W-1:0]   secondary_reading,
	input  wire logic [eca_pkg::PWR_W-1:0]   power_reading,
	input  wire logic [eca_pkg::TIME_W-1:0]  elapsed_time,
	// toward the queue
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output eca_pkg::entry_t                  push_entry
);

	localparam int CW = eca_pkg::CNT_W;
	localparam int DW = eca_pkg::DELTA_W;

	logic [CW-1:0]             primary_max_range_q;
	logic [eca_pkg::PWR_W-1:0] fallback_power_q;
	logic [CW-1:0]             last_primary_q;
	logic [CW-1:0]             last_secondary_q;

	logic            valid_s1;
	eca_pkg::entry_t entry_s1;

	logic accept;
	logic p_use;
	logic s_use;

	logic [CW:0]   p_diff;
	logic          p_ge;
	logic          head_ok;
	logic [CW+1:0] wrap_sum;
	logic [DW-1:0] p_delta;

	logic [CW:0]   s_diff;
	logic [DW-1:0] s_delta;

	logic [eca_pkg::PWR_W-1:0]  pwr_sel;
	logic [eca_pkg::PROD_W-1:0] product;
	logic [DW-1:0]              e_delta;
	eca_pkg::src_t              e_src;

	eca_pkg::entry_t entry_d;

	assign in_stall = valid_s1 && !push_ready;
	assign accept   = in_valid && !in_stall;

	// pick the first usable source
	assign p_use = primary_present && (primary_reading != '0);
	assign s_use = secondary_present && (secondary_reading != '0);

	// primary delta, including wrap through the configured range
	always_comb begin
		p_diff   = {1'b0, primary_reading} - {1'b0, last_primary_q};
		p_ge     = !p_diff[CW];
		head_ok  = primary_max_range_q >= last_primary_q;
		wrap_sum = {2'b00, primary_max_range_q} + {2'b00, primary_reading}
			- {2'b00, last_primary_q};
		if (last_primary_q == '0) begin
			p_delta = '0;
		end else if (p_ge) begin
			p_delta = DW'(p_diff[CW-1:0]);
		end else if (primary_max_range_q == '0) begin
			p_delta = '0;
		end else if (head_ok) begin
			p_delta = DW'(wrap_sum[CW:0]);
		end else begin
			p_delta = DW'(primary_reading);
		end
	end

	// secondary delta, a wrap adds nothing
	always_comb begin
		s_diff = {1'b0, secondary_reading} - {1'b0, last_secondary_q};
		if (last_secondary_q != '0 && !s_diff[CW]) begin
			s_delta = DW'(s_diff[CW-1:0]);
		end else begin
			s_delta = '0;
		end
	end

	// power estimate, falling back to the design power
	always_comb begin
		if (power_reading == '0 && fallback_power_q != '0) begin
			pwr_sel = fallback_power_q;
			e_src   = eca_pkg::SRC_FALLBACK;
		end else begin
			pwr_sel = power_reading;
			e_src   = eca_pkg::SRC_POWER;
		end
		product = eca_pkg::PROD_W'(pwr_sel) * eca_pkg::PROD_W'(elapsed_time);
		e_delta = DW'(product[eca_pkg::PROD_W-1:eca_pkg::FRAC_W]);
	end

	always_comb begin
		if (p_use) begin
			entry_d.delta = p_delta;
			entry_d.src   = eca_pkg::SRC_PRIMARY;
		end else if (s_use) begin
			entry_d.delta = s_delta;
			entry_d.src   = eca_pkg::SRC_SECONDARY;
		end else begin
			entry_d.delta = e_delta;
			entry_d.src   = e_src;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_max_range_q <= '0;
			fallback_power_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				eca_pkg::CFG_PRIMARY_MAX_RANGE: primary_max_range_q <= cfg_data;
				eca_pkg::CFG_FALLBACK_POWER:    fallback_power_q <= cfg_data[eca_pkg::PWR_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the last value of the counter that was used, on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_primary_q   <= '0;
			last_secondary_q <= '0;
		end else if (accept) begin
			if (p_use) begin
				last_primary_q <= primary_reading;
			end else if (s_use) begin
				last_secondary_q <= secondary_reading;
			end
		end
	end

	// hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

endmodule
`default_nettype wire

### sv/eca_queue.sv
`default_nettype none
module eca_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire eca_pkg::entry_t  push_entry,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output eca_pkg::entry_t       pop_entry
);

	eca_pkg::entry_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	logic push;
	logic pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = slot_q[rd_ptr_q];

	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	// store an item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/eca_back.sv
`default_nettype none
module eca_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire eca_pkg::entry_t               pop_entry,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [eca_pkg::TOTAL_W-1:0]        energy_total,
	output logic [1:0]                         source_used
);

	localparam int TW = eca_pkg::TOTAL_W;

	logic [TW-1:0] running_total_q;
	logic          out_valid_q;
	logic [TW-1:0] energy_total_q;
	eca_pkg::src_t source_used_q;

	logic          take;
	logic [TW:0]   sum;
	logic [TW-1:0] total_d;

	assign pop_ready = !out_valid_q || !out_stall;
	assign take      = pop_valid && pop_ready;

	// saturating add of the delta
	always_comb begin
		sum = {1'b0, running_total_q} + (TW + 1)'(pop_entry.delta);
		if (sum[TW]) begin
			total_d = '1;
		end else begin
			total_d = sum[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_total_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (take) begin
				running_total_q <= total_d;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (take) begin
			energy_total_q <= total_d;
			source_used_q  <= pop_entry.src;
		end
	end

	assign out_valid    = out_valid_q;
	assign energy_total = energy_total_q;
	assign source_used  = source_used_q;

endmodule
`default_nettype wire

### sv/energy_counter_accumulator_unit.sv
// An accepted item passes the classify register, a queue slot and the output
// register in turn. Throughput: one item per cycle while out_stall is low;
// the two-slot queue lets front and back stall apart.
// Reset (arst_n low, asynchronous): counter history, running total, configuration
// registers and all valid flags clear to zero.
`default_nettype none
module energy_counter_accumulator_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [eca_pkg::CNT_W-1:0]     cfg_data,
	// sample input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          primary_present,
	input  wire logic [eca_pkg::CNT_W-1:0]     primary_reading,
	input  wire logic                          secondary_present,
	input  wire logic [eca_pkg::CNT_W-1:0]     secondary_reading,
	input  wire logic [eca_pkg::PWR_W-1:0]     power_reading,
	input  wire logic [eca_pkg::TIME_W-1:0]    elapsed_time,
	// result output
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [eca_pkg::TOTAL_W-1:0]        energy_total,
	output logic [1:0]                         source_used
);

	logic            push_valid;
	logic            push_ready;
	eca_pkg::entry_t push_entry;
	logic            pop_valid;
	logic            pop_ready;
	eca_pkg::entry_t pop_entry;

	assign cfg_ready = 1'b1;

	eca_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.primary_present   (primary_present),
		.primary_reading   (primary_reading),
		.secondary_present (secondary_present),
		.secondary_reading (secondary_reading),
		.power_reading     (power_reading),
		.elapsed_time      (elapsed_time),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_entry        (push_entry)
	);

	eca_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	eca_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.energy_total (energy_total),
		.source_used  (source_used)
	);

endmodule
`default_nettype wire
